>>> rtl/rma_pkg.sv
// Package for the range map allocator: table size, index widths,
// entry type, command codes and sequencer states. No dependencies.
`default_nettype none
package rma_pkg;
    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_F_SCAN,
        ST_F_MERGE,
        ST_A_SCAN,
        ST_A_DIV,
        ST_A_CHK,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/range_map_allocator.sv
// Range map allocator top level: sorted free-range table, scan sequencer,
// restoring remainder unit for alignment. Depends on rma_pkg.
// Free: scans for the insertion point, then merges or inserts, then result.
// Allocate: skips entries below the address, checks each candidate, runs the
//   remainder unit when alignment is nonzero; a leading gap adds a free pass.
// One transaction at a time, ready only when idle; sync reset empties table.
`default_nettype none
module range_map_allocator
    import rma_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_length,
    input  wire logic [30:0] i_alignment,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_granted_address,
    output logic             o_alloc_failed,
    output logic             o_range_lost
);
    t_state r_state, n_state;
    t_entry r_tab [TABLE_ENTRIES];
    t_entry n_tab [TABLE_ENTRIES];
    t_entry r_prev, n_prev;
    logic r_have_prev, n_have_prev;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [31:0] r_rb, n_rb, r_rl, n_rl;
    logic [31:0] r_start, n_start;
    logic [30:0] r_align, n_align;
    logic [31:0] r_dx, n_dx;
    logic [30:0] r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_dcnt, n_dcnt;
    logic [31:0] r_granted, n_granted;
    logic r_failed, n_failed, r_lost, n_lost;

    t_entry cur;
    logic idx_end, f_go, merge_lo, merge_hi, ins_top;
    logic a_end, a_before, a_skip, a_past, a_fit;
    logic [31:0] a_d, a_pre, new_len;
    logic [31:0] div_sh;
    logic div_ge;
    logic [IDX_W-1:0] cidx, pidx;
    logic in_acc;
    logic sh_stop;

    assign cidx = r_idx[IDX_W-1:0];
    assign pidx = IDX_W'(r_idx - CNT_W'(1));
    assign idx_end = (r_idx == CNT_W'(TABLE_ENTRIES));
    assign cur = r_tab[cidx];
    assign in_acc = i_in_valid && o_in_ready;

    assign f_go = (r_idx < CNT_W'(TABLE_ENTRIES - 1)) && (cur.len != '0)
                  && (cur.base <= r_rb);
    assign merge_lo = r_have_prev && (r_prev.base + r_prev.len == r_rb);
    assign merge_hi = (cur.len != '0) && (r_rb + r_rl == cur.base);
    assign ins_top = (r_idx == CNT_W'(TABLE_ENTRIES - 1));

    assign a_end = idx_end || (cur.len == '0);
    assign a_d = r_rb - cur.base;
    assign a_before = (r_rb != '0) && (cur.base > r_rb);
    assign a_skip = (r_rb != '0) && (cur.len < a_d);
    assign a_past = (r_rb != '0) && (a_d > cur.len - r_rl);
    assign a_pre = (r_rb != '0) ? r_rb : cur.base;
    assign a_fit = (cur.base + cur.len - r_start) >= r_rl;
    assign new_len = cur.len - (r_start - cur.base + r_rl);

    assign div_sh = {r_rem, r_dx[31]};
    assign div_ge = div_sh >= {1'b0, r_align};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_FREE) begin
                        n_state = (i_length == '0) ? ST_DONE : ST_F_SCAN;
                    end else begin
                        n_state = ST_A_SCAN;
                    end
                end
            end
            ST_F_SCAN: begin
                if (!f_go) begin
                    n_state = ST_F_MERGE;
                end
            end
            ST_F_MERGE: n_state = ST_DONE;
            ST_A_SCAN: begin
                priority if (a_end || a_before) begin
                    n_state = ST_DONE;
                end else if (a_skip) begin
                    n_state = ST_A_SCAN;
                end else if (a_past) begin
                    n_state = ST_DONE;
                end else if (r_align != '0) begin
                    n_state = ST_A_DIV;
                end else begin
                    n_state = ST_A_CHK;
                end
            end
            ST_A_DIV: begin
                if (r_dcnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_A_CHK;
                end
            end
            ST_A_CHK: begin
                priority if (!a_fit) begin
                    n_state = ST_A_SCAN;
                end else if (r_start != cur.base) begin
                    n_state = ST_F_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_tab = r_tab;
        n_prev = r_prev;
        n_have_prev = r_have_prev;
        n_idx = r_idx;
        n_rb = r_rb;
        n_rl = r_rl;
        n_start = r_start;
        n_align = r_align;
        n_dx = r_dx;
        n_rem = r_rem;
        n_dcnt = r_dcnt;
        n_granted = r_granted;
        n_failed = r_failed;
        n_lost = r_lost;
        sh_stop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_rb = i_address;
                    n_rl = i_length;
                    n_align = i_alignment;
                    n_idx = '0;
                    n_have_prev = 1'b0;
                    n_granted = '0;
                    n_failed = 1'b0;
                    n_lost = 1'b0;
                end
            end
            ST_F_SCAN: begin
                if (f_go) begin
                    n_prev = cur;
                    n_have_prev = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_F_MERGE: begin
                priority if (merge_lo) begin
                    n_tab[pidx].len = r_prev.len + r_rl + (merge_hi ? cur.len : 32'd0);
                    if (merge_hi) begin
                        for (int k = 0; k < TABLE_ENTRIES; k++) begin
                            if (CNT_W'(k) >= r_idx && !sh_stop) begin
                                n_tab[k] = (k < TABLE_ENTRIES - 1) ?
                                           r_tab[(k + 1) % TABLE_ENTRIES] : '0;
                                sh_stop = (k < TABLE_ENTRIES - 1) ?
                                          (r_tab[(k + 1) % TABLE_ENTRIES].len == '0) : 1'b1;
                            end
                        end
                    end
                end else if (merge_hi) begin
                    n_tab[cidx].base = cur.base - r_rl;
                    n_tab[cidx].len = cur.len + r_rl;
                end else if (ins_top) begin
                    n_lost = 1'b1;
                end else begin
                    // shift up until an end entry has been displaced
                    for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
                        if (CNT_W'(k) >= r_idx && !sh_stop) begin
                            if (CNT_W'(k) == r_idx) begin
                                n_tab[k].base = r_rb;
                                n_tab[k].len = r_rl;
                            end else begin
                                n_tab[k] = r_tab[(k + TABLE_ENTRIES - 1) % TABLE_ENTRIES];
                            end
                            sh_stop = (r_tab[k].len == '0);
                        end
                    end
                    n_lost = !sh_stop;
                end
            end
            ST_A_SCAN: begin
                priority if (a_end || a_before) begin
                    n_failed = 1'b1;
                end else if (a_skip) begin
                    n_idx = r_idx + CNT_W'(1);
                end else if (a_past) begin
                    n_failed = 1'b1;
                end else begin
                    n_start = a_pre;
                    n_dx = a_pre + {1'b0, r_align} - 32'd1;
                    n_rem = '0;
                    n_dcnt = '0;
                end
            end
            ST_A_DIV: begin
                n_rem = div_ge ? 31'(div_sh - {1'b0, r_align}) : div_sh[30:0];
                n_dx = {r_dx[30:0], 1'b0};
                n_dcnt = r_dcnt + DIV_CNT_W'(1);
                if (r_dcnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    // dividend fully shifted out; rebuild it from the start
                    n_start = (r_start + {1'b0, r_align} - 32'd1) - {1'b0, n_rem};
                end
            end
            ST_A_CHK: begin
                if (!a_fit) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_granted = r_start;
                    if (new_len == '0) begin
                        for (int k = 0; k < TABLE_ENTRIES; k++) begin
                            if (CNT_W'(k) >= r_idx && !sh_stop) begin
                                n_tab[k] = (k < TABLE_ENTRIES - 1) ?
                                           r_tab[(k + 1) % TABLE_ENTRIES] : '0;
                                sh_stop = (k < TABLE_ENTRIES - 1) ?
                                          (r_tab[(k + 1) % TABLE_ENTRIES].len == '0) : 1'b1;
                            end
                        end
                    end else begin
                        n_tab[cidx].base = r_start + r_rl;
                        n_tab[cidx].len = new_len;
                    end
                    // leading alignment gap goes back through the free path
                    n_rb = cur.base;
                    n_rl = r_start - cur.base;
                    n_idx = '0;
                    n_have_prev = 1'b0;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_tab[k] <= '0;
            end
            r_have_prev <= 1'b0;
            r_idx <= '0;
            r_dcnt <= '0;
            r_granted <= '0;
            r_failed <= 1'b0;
            r_lost <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tab <= n_tab;
            r_have_prev <= n_have_prev;
            r_idx <= n_idx;
            r_dcnt <= n_dcnt;
            r_granted <= n_granted;
            r_failed <= n_failed;
            r_lost <= n_lost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_rb <= n_rb;
        r_rl <= n_rl;
        r_start <= n_start;
        r_align <= n_align;
        r_dx <= n_dx;
        r_rem <= n_rem;
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_DONE);
        o_granted_address = r_granted;
        o_alloc_failed = r_failed;
        o_range_lost = r_lost;
    end
endmodule
`default_nettype wire

>>> rtl/rma_checker.sv
// Port-level checks for range_map_allocator, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none
module rma_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_command,
    input wire logic [31:0] i_address,
    input wire logic [31:0] i_length,
    input wire logic [30:0] i_alignment,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_granted_address,
    input wire logic        o_alloc_failed,
    input wire logic        o_range_lost
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
        o_out_valid && $stable(o_granted_address) && $stable(o_alloc_failed)
        && $stable(o_range_lost))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alloc_failed |-> o_granted_address == '0)
        else $error("failed allocation with nonzero address");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a transaction");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind range_map_allocator rma_checker u_rma_checker (.*);
`default_nettype wire
